// File: hw/rtl/bfe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfe_pkg
// Shared types and constants for the block floating-point 8-bit encoder.
// ----------------------------------------------------------------------------
package bfe_pkg;

  localparam int BFE_BLOCK_SIZE = 16;

  localparam int VALUE_W = 32;
  localparam int CODE_W  = 8;
  localparam int EXP_W   = 8;

  // float32 field positions
  localparam int SIGN_BIT = 31;
  localparam int EXP_MSB  = 30;
  localparam int EXP_LSB  = 23;

  typedef enum logic [0:0] {
    ST_LOAD = 1'b0,
    ST_EMIT = 1'b1
  } bfe_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // accept one word into the store
    logic rd_en;    // read one stored word for encoding
  } bfe_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic fill_last;  // next word loaded completes the block
    logic rd_last;    // current read is the final word of the block
  } bfe_sts_t;

endpackage
`default_nettype wire

// File: hw/rtl/bfe_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/bfe_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfe_ctrl
// Controller: alternates between filling a block and reading it out.
// ----------------------------------------------------------------------------
module bfe_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire bfe_pkg::bfe_sts_t sts,
  output bfe_pkg::bfe_cmd_t      cmd,
  output logic                   busy
);

  bfe_pkg::bfe_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfe_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bfe_pkg::ST_LOAD: begin
        if (start && sts.fill_last) begin
          state_nxt = bfe_pkg::ST_EMIT;
        end
      end
      bfe_pkg::ST_EMIT: begin
        if (sts.rd_last) begin
          state_nxt = bfe_pkg::ST_LOAD;
        end
      end
      default: state_nxt = bfe_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b0;
    case (state_r)
      bfe_pkg::ST_LOAD: begin
        cmd.load = start;
      end
      bfe_pkg::ST_EMIT: begin
        busy      = 1'b1;
        cmd.rd_en = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/bfe_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfe_dp
// Datapath: block store, max-exponent / sign tracking, per-word encoder and
// output registers.
// ----------------------------------------------------------------------------
module bfe_dp #(
  parameter int BLOCK_SIZE = bfe_pkg::BFE_BLOCK_SIZE
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire bfe_pkg::bfe_cmd_t             cmd,
  output bfe_pkg::bfe_sts_t                  sts,
  input  wire logic [bfe_pkg::VALUE_W-1:0]   in_value,
  output logic                               out_valid,
  output logic      [bfe_pkg::CODE_W-1:0]    out_code,
  output logic      [bfe_pkg::EXP_W-1:0]     out_shared_exponent,
  output logic                               out_all_positive,
  output logic                               out_last
);

  localparam int AW = $clog2(BLOCK_SIZE);
  localparam logic [AW-1:0] LAST_IDX = AW'(BLOCK_SIZE - 1);

  // Encode one word against the shared exponent.
  function automatic logic [bfe_pkg::CODE_W-1:0] encode_word(
    input logic [bfe_pkg::VALUE_W-1:0] word,
    input logic [bfe_pkg::EXP_W-1:0]   shared
  );
    logic [bfe_pkg::EXP_W-1:0] expo;
    logic [bfe_pkg::EXP_W-1:0] d;
    logic [3:0]                m;
    logic [4:0]                mo5;
    logic [3:0]                mo;
    logic [4:0]                hid;
    logic [2:0]                off;
    logic                      guard;
    logic                      sticky;
    expo   = word[bfe_pkg::EXP_MSB:bfe_pkg::EXP_LSB];
    d      = (shared >= expo) ? (shared - expo) : '0;
    m      = word[22:19];
    guard  = word[18];
    sticky = |word[17:0];
    mo5    = {1'b0, m} + {4'b0, guard & (sticky | m[0])};
    mo     = mo5[3:0];
    // mantissa carry: keep unrounded at offset 0, else drop offset by one
    if (mo5[4]) begin
      if (d == '0) begin
        mo = m;
      end else begin
        mo = 4'd0;
        d  = d - 8'd1;
      end
    end
    if (d inside {[8'd8:8'd11]}) begin
      hid = {1'b1, mo} >> (d[2:0] - 3'd6);
      mo  = hid[3:0];
      off = 3'd7;
    end else if (d >= 8'd12) begin
      mo  = 4'd0;
      off = 3'd7;
    end else begin
      off = d[2:0];
    end
    return {word[bfe_pkg::SIGN_BIT], off, mo};
  endfunction

  logic [AW-1:0]               fill_r, fill_nxt;
  logic [AW-1:0]               rd_idx_r, rd_idx_nxt;
  logic [bfe_pkg::EXP_W-1:0]   max_r, max_nxt;
  logic                        pos_r, pos_nxt;
  logic [bfe_pkg::EXP_W-1:0]   shared_r;
  logic                        allpos_r;
  logic                        rd_vld_r;
  logic                        rd_last_r;
  logic [bfe_pkg::VALUE_W-1:0] rd_data;
  logic [bfe_pkg::EXP_W-1:0]   in_exp;
  logic [bfe_pkg::EXP_W-1:0]   max_upd;
  logic                        pos_upd;

  logic                        out_valid_r;
  logic [bfe_pkg::CODE_W-1:0]  out_code_r;
  logic [bfe_pkg::EXP_W-1:0]   out_shexp_r;
  logic                        out_allpos_r;
  logic                        out_last_r;

  bfe_ram #(
    .WIDTH (bfe_pkg::VALUE_W),
    .DEPTH (BLOCK_SIZE)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.load),
    .wr_addr (fill_r),
    .wr_data (in_value),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_idx_r),
    .rd_data (rd_data)
  );

  assign sts.fill_last = (fill_r == LAST_IDX);
  assign sts.rd_last   = (rd_idx_r == LAST_IDX);

  assign in_exp  = in_value[bfe_pkg::EXP_MSB:bfe_pkg::EXP_LSB];
  assign max_upd = (in_exp > max_r) ? in_exp : max_r;
  assign pos_upd = pos_r & ~in_value[bfe_pkg::SIGN_BIT];

  always_comb begin
    fill_nxt   = fill_r;
    max_nxt    = max_r;
    pos_nxt    = pos_r;
    rd_idx_nxt = rd_idx_r;
    if (cmd.load) begin
      if (sts.fill_last) begin
        // block complete: accumulators restart for the next block
        fill_nxt = '0;
        max_nxt  = '0;
        pos_nxt  = 1'b1;
      end else begin
        fill_nxt = fill_r + AW'(1);
        max_nxt  = max_upd;
        pos_nxt  = pos_upd;
      end
    end
    if (cmd.rd_en) begin
      rd_idx_nxt = sts.rd_last ? '0 : rd_idx_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      rd_idx_r    <= '0;
      max_r       <= '0;
      pos_r       <= 1'b1;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      rd_idx_r    <= rd_idx_nxt;
      max_r       <= max_nxt;
      pos_r       <= pos_nxt;
      rd_vld_r    <= cmd.rd_en;
      out_valid_r <= rd_vld_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load && sts.fill_last) begin
      shared_r <= max_upd;
      allpos_r <= pos_upd;
    end
    rd_last_r <= cmd.rd_en & sts.rd_last;
    if (rd_vld_r) begin
      out_code_r   <= encode_word(rd_data, shared_r);
      out_shexp_r  <= shared_r;
      out_allpos_r <= allpos_r;
      out_last_r   <= rd_last_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_code            = out_code_r;
  assign out_shared_exponent = out_shexp_r;
  assign out_all_positive    = out_allpos_r;
  assign out_last            = out_last_r;

endmodule
`default_nettype wire

// File: hw/rtl/block_float_8bit_encoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// block_float_8bit_encoder
// Collects BLOCK_SIZE float32 words, then emits one 8-bit shared-exponent
// code per word in arrival order.
// The first code strobes after the block's last word is taken, once read-out
//   has begun and the word has passed the store read and output registers;
//   codes follow one per cycle, out_last on the final one. No word is taken
//   while a block is read out: loading and read-out alternate.
// busy is high during read-out. Synchronous active-low reset empties the block.
// ----------------------------------------------------------------------------
module block_float_8bit_encoder #(
  parameter int BLOCK_SIZE = bfe_pkg::BFE_BLOCK_SIZE
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [bfe_pkg::VALUE_W-1:0]   in_value,
  output logic                               out_valid,
  output logic      [bfe_pkg::CODE_W-1:0]    out_code,
  output logic      [bfe_pkg::EXP_W-1:0]     out_shared_exponent,
  output logic                               out_all_positive,
  output logic                               out_last
);

  bfe_pkg::bfe_cmd_t cmd;
  bfe_pkg::bfe_sts_t sts;

  bfe_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  bfe_dp #(
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_value            (in_value),
    .out_valid           (out_valid),
    .out_code            (out_code),
    .out_shared_exponent (out_shared_exponent),
    .out_all_positive    (out_all_positive),
    .out_last            (out_last)
  );

  // read-out only begins after a word was taken
  a_emit_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("read-out started without a completing word");

  // every read-out cycle yields a code after the store read and output registers
  a_read_to_code: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> ##2 out_valid)
    else $error("missing code after store read");

  // the final code of a block is never directly followed by another
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("code emitted right after end of block");

endmodule
`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives float32 words into block_float_8bit_encoder one block at a time and
// predicts each block's 8-bit shared-exponent codes. Every code word that
// strobes out is checked field by field against the oldest prediction. The
// stimulus starts with one directed block of corner cases and is followed by
// random blocks, with random sender gaps and three drain pauses.
// ----------------------------------------------------------------------------
module testbench;

  localparam int  BLK         = bfe_pkg::BFE_BLOCK_SIZE;
  localparam int  VALUE_W     = bfe_pkg::VALUE_W;
  localparam int  CODE_W      = bfe_pkg::CODE_W;
  localparam int  EXP_W       = bfe_pkg::EXP_W;
  localparam int  RAND_BLOCKS = 18;
  localparam int  TAIL_WORDS  = 5;
  localparam int  CYCLE_LIMIT = 20000;
  localparam int  IDLE_PCT    = 11;
  localparam int  CALM_FIRST  = 120;  // no sender gaps for words [CALM_FIRST, CALM_LAST)
  localparam int  CALM_LAST   = 200;
  localparam int  DRAIN_WAIT  = 8;

  localparam logic [31:0] SIGN_MASK   = 32'h8000_0000;
  localparam logic [31:0] EXP_MASK    = 32'h7F80_0000;
  localparam logic [31:0] MAN_MASK    = 32'h007F_FFFF;
  localparam logic [22:0] STICKY_MASK = 23'h3_FFFF;
  localparam logic [4:0]  HIDDEN_ONE  = 5'h10;

  typedef enum int {
    SIGNS_POSITIVE,
    SIGNS_MIXED,
    SIGNS_MOSTLY_NEG
  } sign_mode_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    bit                 drain_before;
  } word_req_t;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic [EXP_W-1:0]  shexp;
    logic              all_pos;
    logic              last;
  } code_word_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic [VALUE_W-1:0] in_value = '0;
  logic               busy;
  logic               out_valid;
  logic [CODE_W-1:0]  out_code;
  logic [EXP_W-1:0]   out_shared_exponent;
  logic               out_all_positive;
  logic               out_last;

  word_req_t  pending_words[$];
  code_word_t codes_due[$];
  word_req_t  next_req;
  code_word_t due;

  // predictor state
  logic [VALUE_W-1:0] held_words[BLK];
  int                 held_count = 0;
  logic [EXP_W-1:0]   peak_exp = '0;
  logic               none_negative = 1'b1;

  int  err_count = 0;
  int  total_words = 0;
  int  taken_words = 0;
  int  sent_words = 0;
  int  cycles = 0;
  bit  word_taken = 1'b0;

  block_float_8bit_encoder dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_value            (in_value),
    .out_valid           (out_valid),
    .out_code            (out_code),
    .out_shared_exponent (out_shared_exponent),
    .out_all_positive    (out_all_positive),
    .out_last            (out_last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [CODE_W-1:0] quantize_word(logic [31:0] w,
                                                      logic [EXP_W-1:0] shexp);
    logic        sgn;
    logic [7:0]  ex;
    logic [22:0] man;
    int unsigned gap;
    logic [3:0]  m;
    logic [4:0]  mr;
    logic [2:0]  off;
    sgn  = (w & SIGN_MASK) != 0;
    ex   = 8'((w & EXP_MASK) >> 23);
    man  = 23'(w & MAN_MASK);
    gap  = (shexp >= ex) ? int'(shexp) - int'(ex) : 0;
    m    = man[22:19];
    mr   = {1'b0, m};
    if (man[18] && (((man & STICKY_MASK) != 0) || m[0]))
      mr = mr + 5'd1;
    // rounding overflow: keep the truncated nibble at the top, else clear it and step the offset down one
    if (mr[4]) begin
      if (gap == 0) begin
        mr = {1'b0, m};
      end else begin
        mr  = '0;
        gap = gap - 1;
      end
    end
    if (gap >= 8 && gap <= 11) begin
      mr  = (mr | HIDDEN_ONE) >> (gap - 6);
      off = 3'd7;
    end else if (gap >= 12) begin
      mr  = '0;
      off = 3'd7;
    end else begin
      off = 3'(gap);
    end
    return {sgn, off, mr[3:0]};
  endfunction

  task automatic absorb_word(logic [VALUE_W-1:0] w);
    logic [7:0] ex;
    code_word_t cw;
    ex = 8'((w & EXP_MASK) >> 23);
    held_words[held_count] = w;
    held_count++;
    if (ex > peak_exp)
      peak_exp = ex;
    if ((w & SIGN_MASK) != 0)
      none_negative = 1'b0;
    if (held_count == BLK) begin
      for (int k = 0; k < BLK; k++) begin
        cw.code    = quantize_word(held_words[k], peak_exp);
        cw.shexp   = peak_exp;
        cw.all_pos = none_negative;
        cw.last    = (k == BLK - 1);
        codes_due.push_back(cw);
      end
      held_count    = 0;
      peak_exp      = '0;
      none_negative = 1'b1;
    end
  endtask

  task automatic queue_word(logic [VALUE_W-1:0] w, bit drain);
    word_req_t r;
    r.value        = w;
    r.drain_before = drain;
    pending_words.push_back(r);
    total_words++;
  endtask

  function automatic logic [31:0] random_word(logic [7:0] top_exp, sign_mode_t mode);
    int unsigned gap;
    logic [7:0]  ex;
    logic [22:0] man;
    logic        sgn;
    case ($urandom_range(3, 0))
      0: gap = 0;
      1: gap = $urandom_range(11, 1);
      2: gap = $urandom_range(15, 12);
      default: gap = $urandom_range(255, 0);
    endcase
    ex = (gap > top_exp) ? 8'd0 : top_exp - 8'(gap);
    case ($urandom_range(3, 0))
      0: man = 23'($urandom);
      1: man = {4'($urandom_range(15, 0)), 1'b1, 18'd0};   // exact tie
      2: man = {5'h1F, 18'($urandom)};                      // mantissa carry
      default: man = {5'($urandom), ($urandom_range(1, 0) != 0) ? 18'($urandom) : 18'd0};
    endcase
    case (mode)
      SIGNS_POSITIVE: sgn = 1'b0;
      SIGNS_MIXED:    sgn = 1'($urandom_range(1, 0));
      default:        sgn = $urandom_range(3, 0) != 0;
    endcase
    return {sgn, ex, man};
  endfunction

  // driver: one word per handshake, changes on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || word_taken) begin
      word_taken = 1'b0;
      if (pending_words.size() == 0) begin
        start <= 1'b0;
      end else if (pending_words[0].drain_before && codes_due.size() != 0) begin
        start <= 1'b0;
      end else if ((sent_words < CALM_FIRST || sent_words >= CALM_LAST) &&
                   $urandom_range(99, 0) < IDLE_PCT) begin
        start <= 1'b0;
      end else begin
        next_req = pending_words.pop_front();
        in_value <= next_req.value;
        start    <= 1'b1;
        sent_words++;
      end
    end
  end

  // monitor: code words and accepted input words, sampled on the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (codes_due.size() == 0) begin
          $error("code word with none expected: code=%h", out_code);
          err_count++;
        end else begin
          due = codes_due.pop_front();
          if (out_code !== due.code) begin
            $error("out_code: expected %h, got %h", due.code, out_code);
            err_count++;
          end
          if (out_shared_exponent !== due.shexp) begin
            $error("out_shared_exponent: expected %h, got %h", due.shexp,
                   out_shared_exponent);
            err_count++;
          end
          if (out_all_positive !== due.all_pos) begin
            $error("out_all_positive: expected %b, got %b", due.all_pos, out_all_positive);
            err_count++;
          end
          if (out_last !== due.last) begin
            $error("out_last: expected %b, got %b", due.last, out_last);
            err_count++;
          end
        end
      end
      if (start && !busy) begin
        absorb_word(in_value);
        taken_words++;
        word_taken = 1'b1;
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [7:0]  top_exp;
    sign_mode_t  mode;

    // directed block; shared exponent comes from the NaN at 0xFF
    queue_word(32'h7FFF_FFFF, 1'b0);  // NaN, carry at zero offset keeps nibble
    queue_word(32'hFF80_0000, 1'b0);  // negative infinity
    queue_word(32'h7F7C_0000, 1'b0);  // carry at offset 1 drops to offset 0
    queue_word(32'hFC0C_0000, 1'b0);  // offset 7, tie with odd nibble rounds up
    queue_word(32'h7B84_0000, 1'b0);  // offset 8, tie with even nibble stays
    queue_word(32'hFB7F_FFFF, 1'b0);  // offset 9 with carry into offset 8
    queue_word(32'h7AAA_AAAA, 1'b0);  // offset 10
    queue_word(32'h7A7F_FFFF, 1'b0);  // offset 11 with carry
    queue_word(32'h79C0_0000, 1'b0);  // offset 12, huge
    queue_word(32'h79FF_FFFF, 1'b0);  // offset 12 with carry into 11
    queue_word(32'h797F_FFFF, 1'b0);  // offset 13 with carry into 12
    queue_word(32'h0000_0000, 1'b0);  // zero
    queue_word(32'h8000_0000, 1'b0);  // negative zero
    queue_word(32'h007F_FFFF, 1'b0);  // denormal
    queue_word(32'h4044_0001, 1'b0);  // guard plus sticky
    queue_word(32'hFFFF_FFFF, 1'b0);  // negative NaN

    for (int b = 0; b < RAND_BLOCKS; b++) begin
      case (b % 5)
        0: top_exp = 8'd0;
        1: top_exp = 8'd255;
        default: top_exp = 8'($urandom_range(255, 0));
      endcase
      mode = sign_mode_t'(b % 3);
      for (int i = 0; i < BLK; i++)
        queue_word(random_word(top_exp, mode),
                   (b == 0 && i == 0) || (b == 5 && i == 7) || (b == 11 && i == 0));
    end
    // trailing partial block, never completed
    for (int i = 0; i < TAIL_WORDS; i++)
      queue_word(32'($urandom), 1'b0);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    while (taken_words < total_words || codes_due.size() != 0)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/bfe_pkg.sv
hw/rtl/bfe_ram.sv
hw/rtl/bfe_ctrl.sv
hw/rtl/bfe_dp.sv
hw/rtl/block_float_8bit_encoder.sv
bench/testbench.sv
